>>> rtl/crclf_pkg.sv
// Package for the length-prefixed CRC-16 byte framer.
// Holds the frame constants, the output slot type and the CRC byte update.
// No dependencies.
`timescale 1ns / 1ps

package crclf_pkg;

    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'h1021;
    localparam logic [15:0] CRC_TOPBIT = 16'h8000;
    localparam logic [7:0]  MARK_FIRST  = 8'hAA;
    localparam logic [7:0]  MARK_SECOND = 8'h55;

    typedef enum logic [6:0] {
        S_HDR0   = 7'b000_0001,
        S_HDR1   = 7'b000_0010,
        S_LEN_HI = 7'b000_0100,
        S_LEN_LO = 7'b000_1000,
        S_DATA   = 7'b001_0000,
        S_CRC_HI = 7'b010_0000,
        S_CRC_LO = 7'b100_0000
    } t_slot;

    function automatic logic [15:0] crc_byte_update(input logic [15:0] crc,
                                                    input logic [7:0]  b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if ((c & CRC_TOPBIT) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

>>> rtl/crc16_length_framer.sv
// Top level of the length-prefixed framer with CRC-16/CCITT-FALSE.
// Uses crclf_pkg for constants, the slot type and the CRC byte update.
//
//   channel | direction | handshake         | beat
//   input   | in        | i_valid / o_stall | i_payload_byte, i_frame_length
//   output  | out       | o_valid / i_stall | o_out_byte, o_last_of_frame
//
// One output beat per cycle at most, while i_stall is low. A mid-frame payload byte yields
// one output byte, a frame's first byte five (header, length, data), and a frame's last
// byte two more for the CRC.
// The next beat is taken in the cycle the current one's final byte is loaded into the output register.
// Synchronous active-low reset returns the framer to idle with CRC 0xFFFF.
// A zero length at idle is taken and dropped without output.
`timescale 1ns / 1ps

module crc16_length_framer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_payload_byte,
    input  logic [15:0] i_frame_length,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_frame
);
    import crclf_pkg::*;

    logic [15:0] r_crc,        n_crc;
    logic [15:0] r_remaining,  n_remaining;
    logic        r_item_valid, n_item_valid;
    t_slot       r_slot,       n_slot;
    logic        r_out_valid,  n_out_valid;

    logic [7:0]  r_item_byte;
    logic [15:0] r_item_len;
    logic [15:0] r_item_crc;
    logic        r_item_tail;
    logic [7:0]  r_out_byte,   n_out_byte;
    logic        r_out_last,   n_out_last;

    logic        w_idle;
    logic        w_drop;
    logic        w_accept;
    logic        w_load;
    logic        w_advance;
    logic        w_last_slot;
    logic [15:0] w_crc_new;
    logic [15:0] w_rem_new;
    logic        w_tail;
    t_slot       w_slot_after;

    assign w_idle      = (r_remaining == 16'h0000);
    assign w_drop      = w_idle && (i_frame_length == 16'h0000);
    assign w_advance   = r_item_valid && (!r_out_valid || !i_stall);
    assign w_last_slot = ((r_slot == S_DATA) && !r_item_tail) || (r_slot == S_CRC_LO);
    assign o_stall     = r_item_valid && !(w_advance && w_last_slot);
    assign w_accept    = i_valid && !o_stall;
    assign w_load      = w_accept && !w_drop;

    assign w_crc_new = crc_byte_update(w_idle ? CRC_INIT : r_crc, i_payload_byte);
    assign w_rem_new = (w_idle ? i_frame_length : r_remaining) - 16'h0001;
    assign w_tail    = (w_rem_new == 16'h0000);

    always_comb begin
        n_out_byte   = r_out_byte;
        n_out_last   = 1'b0;
        w_slot_after = S_DATA;
        unique case (r_slot)
            S_HDR0: begin
                n_out_byte   = MARK_FIRST;
                w_slot_after = S_HDR1;
            end
            S_HDR1: begin
                n_out_byte   = MARK_SECOND;
                w_slot_after = S_LEN_HI;
            end
            S_LEN_HI: begin
                n_out_byte   = r_item_len[15:8];
                w_slot_after = S_LEN_LO;
            end
            S_LEN_LO: begin
                n_out_byte   = r_item_len[7:0];
                w_slot_after = S_DATA;
            end
            S_DATA: begin
                n_out_byte   = r_item_byte;
                w_slot_after = S_CRC_HI;
            end
            S_CRC_HI: begin
                n_out_byte   = r_item_crc[15:8];
                w_slot_after = S_CRC_LO;
            end
            S_CRC_LO: begin
                n_out_byte   = r_item_crc[7:0];
                n_out_last   = 1'b1;
                w_slot_after = S_DATA;
            end
            default: begin
                n_out_byte   = r_out_byte;
                w_slot_after = S_DATA;
            end
        endcase
        if (!w_advance) begin
            n_out_byte = r_out_byte;
            n_out_last = r_out_last;
        end
    end

    always_comb begin
        n_crc        = r_crc;
        n_remaining  = r_remaining;
        n_item_valid = r_item_valid;
        n_slot       = r_slot;
        n_out_valid  = w_advance || (r_out_valid && i_stall);
        if (w_advance) begin
            if (w_last_slot) begin
                n_item_valid = 1'b0;
            end else begin
                n_slot = w_slot_after;
            end
        end
        if (w_load) begin
            n_crc        = w_tail ? CRC_INIT : w_crc_new;
            n_remaining  = w_rem_new;
            n_item_valid = 1'b1;
            n_slot       = w_idle ? S_HDR0 : S_DATA;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc        <= CRC_INIT;
            r_remaining  <= 16'h0000;
            r_item_valid <= 1'b0;
            r_slot       <= S_DATA;
            r_out_valid  <= 1'b0;
        end else begin
            r_crc        <= n_crc;
            r_remaining  <= n_remaining;
            r_item_valid <= n_item_valid;
            r_slot       <= n_slot;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item_byte <= i_payload_byte;
            r_item_len  <= i_frame_length;
            r_item_crc  <= w_crc_new;
            r_item_tail <= w_tail;
        end
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    assign o_valid         = r_out_valid;
    assign o_out_byte      = r_out_byte;
    assign o_last_of_frame = r_out_last;

endmodule

>>> bench/crc16_length_framer_monitor.sv
// Beat monitor for crc16_length_framer: predicts the framed byte stream from accepted
// input beats and compares every accepted output beat. Depends on crclf_pkg constants.
`timescale 1ns / 1ps

module crc16_length_framer_monitor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_in_byte,
    input  logic [15:0] i_in_length,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [7:0]  i_out_byte,
    input  logic        i_out_last,
    output int          o_mismatch_count,
    output int          o_beats_due
);
    import crclf_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_framed_beat;

    t_framed_beat framed_bytes_due[$];
    t_framed_beat due_beat;
    logic [15:0]  crc_acc;
    logic [15:0]  bytes_left;
    int           mismatch_count;

    function automatic logic [15:0] crc_ccitt_step(input logic [15:0] acc,
                                                   input logic [7:0]  b);
        logic [15:0] r;
        logic        fb;
        r = acc;
        for (int k = 7; k >= 0; k--) begin
            fb = r[15] ^ b[k];
            r  = {r[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return r;
    endfunction

    function automatic void due_push(input logic [7:0] d, input logic l);
        t_framed_beat fb;
        fb.data = d;
        fb.last = l;
        framed_bytes_due.push_back(fb);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic frame_one_byte(input logic [7:0] b, input logic [15:0] len);
        if (bytes_left == 16'h0000) begin
            if (len == 16'h0000) begin
                return;
            end
            due_push(MARK_FIRST, 1'b0);
            due_push(MARK_SECOND, 1'b0);
            due_push(len[15:8], 1'b0);
            due_push(len[7:0], 1'b0);
            crc_acc    = CRC_INIT;
            bytes_left = len;
        end
        due_push(b, 1'b0);
        crc_acc    = crc_ccitt_step(crc_acc, b);
        bytes_left = bytes_left - 16'd1;
        if (bytes_left == 16'h0000) begin
            due_push(crc_acc[15:8], 1'b0);
            due_push(crc_acc[7:0], 1'b1);
            crc_acc = CRC_INIT;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            crc_acc    = CRC_INIT;
            bytes_left = '0;
            framed_bytes_due.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                frame_one_byte(i_in_byte, i_in_length);
            end
            if (i_out_valid && !i_out_stall) begin
                if (framed_bytes_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat byte=%02h last=%0b",
                                              i_out_byte, i_out_last));
                end else begin
                    due_beat = framed_bytes_due.pop_front();
                    if (i_out_byte !== due_beat.data) begin
                        report_mismatch($sformatf("out_byte %02h, want %02h",
                                                  i_out_byte, due_beat.data));
                    end
                    if (i_out_last !== due_beat.last) begin
                        report_mismatch($sformatf("last_of_frame %0b, want %0b",
                                                  i_out_last, due_beat.last));
                    end
                end
            end
        end
        o_beats_due      <= framed_bytes_due.size();
        o_mismatch_count <= mismatch_count;
    end

endmodule

>>> bench/crc16_length_framer_tb.sv
// Top of the crc16_length_framer bench: clock, reset, byte stimulus and verdict.
// Depends on crc16_length_framer and crc16_length_framer_monitor.
`timescale 1ns / 1ps

module crc16_length_framer_tb;

    localparam int CYCLE_LIMIT = 1_000_000;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_valid        = 1'b0;
    logic [7:0]  i_payload_byte = 8'h00;
    logic [15:0] i_frame_length = 16'h0000;
    logic        i_stall        = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [7:0]  o_out_byte;
    logic        o_last_of_frame;

    logic        steady      = 1'b0;
    int          cycle_count = 0;
    int          mismatches;
    int          beats_due;
    int          bytes_sent;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    crc16_length_framer DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_payload_byte  (i_payload_byte),
        .i_frame_length  (i_frame_length),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_out_byte      (o_out_byte),
        .o_last_of_frame (o_last_of_frame)
    );

    crc16_length_framer_monitor u_monitor (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_valid),
        .i_in_stall       (o_stall),
        .i_in_byte        (i_payload_byte),
        .i_in_length      (i_frame_length),
        .i_out_valid      (o_valid),
        .i_out_stall      (i_stall),
        .i_out_byte       (o_out_byte),
        .i_out_last       (o_last_of_frame),
        .o_mismatch_count (mismatches),
        .o_beats_due      (beats_due)
    );

    always @(posedge i_clk) begin
        i_stall     <= !steady && ($urandom_range(0, 99) < 25);
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_beat(input logic [7:0] b, input logic [15:0] len);
        while (!steady && $urandom_range(0, 99) < 25) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_payload_byte <= b;
        i_frame_length <= len;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
    endtask

    task automatic send_frame(input int len);
        logic [15:0] mid_len;
        for (int n = 0; n < len; n++) begin
            mid_len = ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom);
            send_beat(8'($urandom_range(0, 255)), (n == 0) ? 16'(len) : mid_len);
        end
    endtask

    initial begin
        int len;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero length at idle, single-byte frames, ignored length mid-frame
        send_beat(8'hFF, 16'h0000);
        send_beat(8'h00, 16'h0001);
        send_beat(8'hFF, 16'h0001);
        send_beat(8'h12, 16'h0002);
        send_beat(8'h34, 16'h0000);
        send_beat(8'h31, 16'h0003);
        send_beat(8'h32, 16'hFFFF);
        send_beat(8'h33, 16'h8000);
        send_beat(8'h00, 16'h0000);
        send_beat(8'h00, 16'h0004);
        send_beat(8'hFF, 16'h5555);
        send_beat(8'h80, 16'hAAAA);
        send_beat(8'h01, 16'h0001);

        bytes_sent = 0;
        while (bytes_sent < 150) begin
            steady <= (bytes_sent >= 50 && bytes_sent < 90);
            if ($urandom_range(0, 9) == 0) begin
                send_beat(8'($urandom_range(0, 255)), 16'h0000);
            end else begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                  : $urandom_range(1, 12);
                send_frame(len);
                bytes_sent += len;
            end
        end
        steady <= 1'b0;

        // all-ones length header, frame left open
        send_beat(8'hA5, 16'hFFFF);
        send_beat(8'($urandom_range(0, 255)), 16'h0000);
        send_beat(8'($urandom_range(0, 255)), 16'h0001);
        i_valid <= 1'b0;

        do begin
            @(posedge i_clk);
        end while (beats_due != 0);
        repeat (32) @(posedge i_clk);

        if (mismatches == 0 && beats_due == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
